### rtl/core/ptfa_pkg.sv
package ptfa_pkg;

  localparam int PACKET_BYTES = 6;
  localparam int POS_W = 6;
  localparam int DATA_W = 8;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_SENSOR_ADDR = 2'd1;
  localparam logic [1:0] REG_REQUEST_TAG = 2'd2;

  // packet count = (size + 3) / 6 + 1, the divide done as (x * 171) >> 10 for x <= 258
  localparam logic [8:0] SIZE_BIAS = 9'd3;
  localparam logic [7:0] DIV6_MUL = 8'd171;
  localparam int DIV6_SHIFT = 10;

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_START,
    PARSE_SENSOR,
    PARSE_DATA
  } parse_state_t;

  typedef struct packed {
    logic en;
    logic [POS_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic en;
    logic [POS_W-1:0] addr;
    logic zero;
  } store_rd_t;

endpackage

### rtl/core/polled_telemetry_frame_assembler_core.sv
// Polled telemetry frame assembler. Received bytes enter on the rx channel, one word per
// accepted cycle, and are matched against the start byte, sensor address and request tag
// registers; each matched packet appends six data bytes to a frame store of
// 6*MAX_PACKETS bytes. The second byte of a frame is its size and fixes the frame at
// (size+3)/6+1 packets. Outside frame output an rx word is taken every cycle. A completed
// frame of n bytes is read from the store's single read port one byte per cycle while
// the output is not stalled, through the registered read word; a frame declaring more than
// MAX_PACKETS packets gives one word with overflow set. The rx channel stalls
// from the end of a frame, kept or dropped, until its last word has been taken
// downstream. No clearing pass follows reset: every store entry that a frame reads was
// written earlier in that same frame.
module polled_telemetry_frame_assembler_core
  import ptfa_pkg::*;
#(
  parameter int MAX_PACKETS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  frame_byte,
  output logic [POS_W-1:0]   byte_position,
  output logic               last_of_frame,
  output logic               overflow,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int STORE_DEPTH = MAX_PACKETS * PACKET_BYTES;
  localparam logic [POS_W-1:0] STORE_LIMIT = POS_W'(STORE_DEPTH);
  localparam logic [POS_W-1:0] COUNT_LIMIT = POS_W'(MAX_PACKETS);
  localparam logic [2:0] PACKET_LAST = 3'(PACKET_BYTES - 1);

  logic [DATA_W-1:0] start_byte;
  logic [DATA_W-1:0] sensor_addr;
  logic [DATA_W-1:0] request_tag;

  parse_state_t      parse_state;
  parse_state_t      parse_state_next;
  logic [POS_W-1:0]  write_position;
  logic [POS_W-1:0]  packet_count;
  logic [2:0]        packet_byte;
  logic              emitting;
  logic [POS_W-1:0]  read_addr;
  logic [POS_W-1:0]  frame_len;

  logic              in_accept;
  logic              cfg_write;
  logic              store_ok;
  logic              data_take;
  logic              packet_done;
  logic              size_seen;
  logic              drop;
  logic              emit_start;
  logic              rd_en;
  logic              read_last;
  logic [POS_W-1:0]  pos_inc;
  logic [8:0]        frame_bytes;
  logic [8:0]        size_biased;
  logic [16:0]       size_prod;
  logic [POS_W-1:0]  size_count;

  store_wr_t         store_wr;
  store_rd_t         store_rd;

  assign in_stall  = emitting || out_valid;
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_START_BYTE:  prdata[DATA_W-1:0] = start_byte;
      REG_SENSOR_ADDR: prdata[DATA_W-1:0] = sensor_addr;
      REG_REQUEST_TAG: prdata[DATA_W-1:0] = request_tag;
      default:         prdata = '0;
    endcase
  end

  // packet and frame bookkeeping
  assign pos_inc     = write_position + 1'b1;
  assign store_ok    = write_position < STORE_LIMIT;
  assign packet_done = packet_byte == PACKET_LAST;
  assign size_seen   = pos_inc == POS_W'(2);
  assign frame_bytes = {1'b0, packet_count, 2'b00} + {2'b00, packet_count, 1'b0};
  assign size_biased = {1'b0, rx_byte} + SIZE_BIAS;
  assign size_prod   = size_biased * DIV6_MUL;
  assign size_count  = POS_W'(size_prod[16:DIV6_SHIFT]) + 1'b1;

  always_comb begin
    parse_state_next = parse_state;
    if (in_accept) begin
      case (parse_state)
        PARSE_IDLE: begin
          if (rx_byte == start_byte) parse_state_next = PARSE_START;
        end
        PARSE_START: begin
          parse_state_next = (rx_byte == sensor_addr) ? PARSE_SENSOR : PARSE_IDLE;
        end
        PARSE_SENSOR: begin
          parse_state_next = (rx_byte == request_tag) ? PARSE_DATA : PARSE_IDLE;
        end
        PARSE_DATA: begin
          if (store_ok && packet_done) parse_state_next = PARSE_IDLE;
        end
        default: parse_state_next = PARSE_IDLE;
      endcase
    end
  end

  always_comb begin
    data_take  = in_accept && (parse_state == PARSE_DATA) && store_ok;
    drop       = data_take && packet_done && (packet_count > COUNT_LIMIT);
    emit_start = data_take && packet_done && !drop
                 && ({3'b000, pos_inc} == frame_bytes);
  end

  // advance the frame read whenever the output word is free or being taken
  assign rd_en     = emitting && (!out_valid || !out_stall);
  assign read_last = read_addr == (frame_len - 1'b1);

  always_comb begin
    store_wr.en   = data_take;
    store_wr.addr = write_position;
    store_wr.data = rx_byte;
    store_rd.en   = rd_en;
    store_rd.addr = read_addr;
    store_rd.zero = drop;
  end

  ptfa_store #(
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .wr    (store_wr),
    .rd    (store_rd),
    .rdata (frame_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte       <= 8'd126;
      sensor_addr      <= 8'd0;
      request_tag      <= 8'd48;
      parse_state      <= PARSE_IDLE;
      write_position   <= '0;
      packet_count     <= '0;
      packet_byte      <= '0;
      emitting         <= 1'b0;
      read_addr        <= '0;
      frame_len        <= '0;
      out_valid        <= 1'b0;
    end else begin
      parse_state <= parse_state_next;

      if (cfg_write) begin
        case (paddr[3:2])
          REG_START_BYTE:  start_byte <= pwdata[DATA_W-1:0];
          REG_SENSOR_ADDR: sensor_addr <= pwdata[DATA_W-1:0];
          REG_REQUEST_TAG: request_tag <= pwdata[DATA_W-1:0];
          default: ;
        endcase
      end

      if (data_take) begin
        if (size_seen) packet_count <= size_count;
        if (drop || emit_start) begin
          write_position <= '0;
          packet_byte    <= '0;
        end else begin
          write_position <= pos_inc;
          packet_byte    <= packet_done ? 3'd0 : packet_byte + 1'b1;
        end
      end

      if (emit_start) begin
        emitting  <= 1'b1;
        read_addr <= '0;
        frame_len <= pos_inc;
      end else if (rd_en) begin
        read_addr <= read_addr + 1'b1;
        if (read_last) emitting <= 1'b0;
      end

      if (rd_en || drop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byte_position <= read_addr;
      last_of_frame <= read_last;
      overflow      <= 1'b0;
    end else if (drop) begin
      byte_position <= '0;
      last_of_frame <= 1'b1;
      overflow      <= 1'b1;
    end
  end

endmodule

### rtl/core/ptfa_store.sv
module ptfa_store
  import ptfa_pkg::*;
#(
  parameter int DEPTH = 60
) (
  input  logic              clk,
  input  store_wr_t         wr,
  input  store_rd_t         rd,
  output logic [DATA_W-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    // read word is registered; zero load serves the dropped-frame result
    if (rd.en) begin
      rdata <= mem[rd.addr[AW-1:0]];
    end else if (rd.zero) begin
      rdata <= '0;
    end
  end

endmodule

### rtl/core/ptfa_checker.sv
module ptfa_checker
  import ptfa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] frame_byte,
  input logic [POS_W-1:0]  byte_position,
  input logic              last_of_frame,
  input logic              overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(byte_position)
      && $stable(last_of_frame) && $stable(overflow))
    else $error("output word changed while stalled");

  a_drop_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> last_of_frame && (frame_byte == '0) && (byte_position == '0))
    else $error("dropped-frame word is malformed");

  a_frame_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_frame
      |=> out_valid && (byte_position == $past(byte_position) + 6'd1))
    else $error("frame bytes not streamed in order");

  a_rx_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("rx word taken while a result is pending");

endmodule

bind polled_telemetry_frame_assembler_core ptfa_checker u_ptfa_checker (.*);
